// ===== hdl/button_gesture_debouncer_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the button gesture debouncer
// Short wrappers around concurrent assertions with an active-low reset.
// ----------------------------------------------------------------------------
`ifndef BUTTON_GESTURE_DEBOUNCER_ASSERT_SVH
`define BUTTON_GESTURE_DEBOUNCER_ASSERT_SVH

// Property must hold at every clock edge outside reset
`define BGD_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("bgd assertion failed");

// Antecedent implies consequent in the same cycle, outside reset
`define BGD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bgd implication failed");

// Antecedent implies consequent in the next cycle, outside reset
`define BGD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bgd next-cycle implication failed");

`endif

// ===== hdl/bgd_pkg.sv =====
// ----------------------------------------------------------------------------
// bgd_pkg
// Shared constants and helper functions of the button gesture debouncer.
// ----------------------------------------------------------------------------
package bgd_pkg;

  // Default sample window depth
  localparam int unsigned WINDOW_SAMPLES_DEF = 16;

  // Register indexes (byte address is 4 * index)
  localparam logic [2:0] REG_ACTIVE_LOW    = 3'd0;
  localparam logic [2:0] REG_THRESHOLD_PCT = 3'd1;
  localparam logic [2:0] REG_SAMPLE_US     = 3'd2;
  localparam logic [2:0] REG_LONG_EN       = 3'd3;
  localparam logic [2:0] REG_LONG_MS       = 3'd4;
  localparam logic [2:0] REG_DOUBLE_EN     = 3'd5;
  localparam logic [2:0] REG_DOUBLE_WIN_MS = 3'd6;
  localparam logic [2:0] REG_TIMEOUT_MS    = 3'd7;

  // Register reset values
  localparam logic [6:0]  RST_THRESHOLD_PCT = 7'd90;
  localparam logic [31:0] RST_SAMPLE_US     = 32'd1000;
  localparam logic [22:0] RST_LONG_MS       = 23'd1000;
  localparam logic [22:0] RST_DOUBLE_WIN_MS = 23'd300;
  localparam logic [22:0] RST_TIMEOUT_MS    = 23'd2000;

  localparam int unsigned PCT_MAX = 100;

  // floor(n / 1000) for 32-bit n equals (n * DIV1000_MUL) >> DIV1000_SHIFT
  localparam int unsigned   DIV1000_SHIFT = 38;
  localparam logic [28:0]   DIV1000_MUL   = 29'd274877907;

  // ceil(samples * pct / 100) via reciprocal: (x * 5243) >> 19 exact for x < 43690
  function automatic int unsigned thr_of(input int unsigned samples,
                                         input logic [6:0] pct);
    logic [31:0] x;
    logic [31:0] q;
    x = 32'(samples) * 32'(pct) + 32'd99;
    q = (x * 32'd5243) >> 19;
    return int'(q);
  endfunction

  // Milliseconds to microseconds, wrapping at 32 bits
  function automatic logic [31:0] ms_to_us(input logic [22:0] ms);
    logic [41:0] p;
    p = 42'(ms) * 42'd1000;
    return p[31:0];
  endfunction

endpackage

// ===== hdl/button_gesture_debouncer.sv =====
// Path: an accepted transaction passes the input register and then the result
// register, which holds its result.
// Throughput: one transaction per cycle while unstalled; the step is one pass of logic
// from input register to result register, the window count kept as a running sum.
// Reset: asynchronous, active low; clears all gesture state and the window and
// returns every configuration register to its default.
// ----------------------------------------------------------------------------
// button_gesture_debouncer
// Window-consensus button debouncer with short, long and double press flags.
// ----------------------------------------------------------------------------
module button_gesture_debouncer #(
  parameter int unsigned WINDOW_SAMPLES = bgd_pkg::WINDOW_SAMPLES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        command_i,
  input  logic [31:0] now_us_i,
  input  logic        pin_level_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        stable_pressed_o,
  output logic        short_press_fire_o,
  output logic        long_press_fire_o,
  output logic [22:0] hold_ms_o,
  output logic        double_press_fire_o,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned ONES_W = $clog2(WINDOW_SAMPLES + 1);
  localparam logic [ONES_W-1:0] THR_RST =
    ONES_W'(bgd_pkg::thr_of(WINDOW_SAMPLES, bgd_pkg::RST_THRESHOLD_PCT));

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic        active_low_q;
  logic [6:0]  thr_pct_q;
  logic [ONES_W-1:0] thr_q;
  logic [31:0] sample_us_q;
  logic        long_en_q;
  logic [22:0] long_ms_q;
  logic [31:0] long_us_q;
  logic        dbl_en_q;
  logic [22:0] dbl_win_ms_q;
  logic [31:0] dbl_win_us_q;
  logic [22:0] timeout_ms_q;
  logic [31:0] timeout_us_q;

  logic       cfg_we;
  logic [2:0] cfg_idx;
  logic       long_en_chg;
  logic       dbl_en_chg;

  assign pready  = 1'b1;
  assign cfg_we  = psel & penable & pwrite;
  assign cfg_idx = paddr[4:2];

  // enable writes that flip the setting also clear related gesture state
  assign long_en_chg = cfg_we && (cfg_idx == bgd_pkg::REG_LONG_EN)
                       && (pwdata[0] != long_en_q);
  assign dbl_en_chg  = cfg_we && (cfg_idx == bgd_pkg::REG_DOUBLE_EN)
                       && (pwdata[0] != dbl_en_q);

  // register writes; ms values are kept in us form as well
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_low_q <= 1'b0;
      thr_pct_q    <= bgd_pkg::RST_THRESHOLD_PCT;
      thr_q        <= THR_RST;
      sample_us_q  <= bgd_pkg::RST_SAMPLE_US;
      long_en_q    <= 1'b0;
      long_ms_q    <= bgd_pkg::RST_LONG_MS;
      long_us_q    <= bgd_pkg::ms_to_us(bgd_pkg::RST_LONG_MS);
      dbl_en_q     <= 1'b0;
      dbl_win_ms_q <= bgd_pkg::RST_DOUBLE_WIN_MS;
      dbl_win_us_q <= bgd_pkg::ms_to_us(bgd_pkg::RST_DOUBLE_WIN_MS);
      timeout_ms_q <= bgd_pkg::RST_TIMEOUT_MS;
      timeout_us_q <= bgd_pkg::ms_to_us(bgd_pkg::RST_TIMEOUT_MS);
    end else if (cfg_we) begin
      unique case (cfg_idx)
        bgd_pkg::REG_ACTIVE_LOW: active_low_q <= pwdata[0];
        bgd_pkg::REG_THRESHOLD_PCT: begin
          if (pwdata[6:0] <= 7'(bgd_pkg::PCT_MAX)) begin
            thr_pct_q <= pwdata[6:0];
            thr_q     <= ONES_W'(bgd_pkg::thr_of(WINDOW_SAMPLES, pwdata[6:0]));
          end
        end
        bgd_pkg::REG_SAMPLE_US: sample_us_q <= pwdata;
        bgd_pkg::REG_LONG_EN:   long_en_q   <= pwdata[0];
        bgd_pkg::REG_LONG_MS: begin
          if (pwdata[22:0] != 23'd0) begin
            long_ms_q <= pwdata[22:0];
            long_us_q <= bgd_pkg::ms_to_us(pwdata[22:0]);
          end
        end
        bgd_pkg::REG_DOUBLE_EN: dbl_en_q <= pwdata[0];
        bgd_pkg::REG_DOUBLE_WIN_MS: begin
          if (pwdata[22:0] != 23'd0) begin
            dbl_win_ms_q <= pwdata[22:0];
            dbl_win_us_q <= bgd_pkg::ms_to_us(pwdata[22:0]);
          end
        end
        bgd_pkg::REG_TIMEOUT_MS: begin
          timeout_ms_q <= pwdata[22:0];
          timeout_us_q <= bgd_pkg::ms_to_us(pwdata[22:0]);
        end
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (cfg_idx)
      bgd_pkg::REG_ACTIVE_LOW:    prdata = {31'd0, active_low_q};
      bgd_pkg::REG_THRESHOLD_PCT: prdata = {25'd0, thr_pct_q};
      bgd_pkg::REG_SAMPLE_US:     prdata = sample_us_q;
      bgd_pkg::REG_LONG_EN:       prdata = {31'd0, long_en_q};
      bgd_pkg::REG_LONG_MS:       prdata = {9'd0, long_ms_q};
      bgd_pkg::REG_DOUBLE_EN:     prdata = {31'd0, dbl_en_q};
      bgd_pkg::REG_DOUBLE_WIN_MS: prdata = {9'd0, dbl_win_ms_q};
      bgd_pkg::REG_TIMEOUT_MS:    prdata = {9'd0, timeout_ms_q};
      default:                    prdata = 32'd0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Input register and handshake
  // --------------------------------------------------------------------------
  logic        s1_valid_q;
  logic        s1_cmd_q;
  logic [31:0] s1_now_q;
  logic        s1_pin_q;
  logic        s1_adv;
  logic        proc;

  assign s1_adv     = !out_valid_o || !out_stall_i;
  assign proc       = s1_valid_q && s1_adv;
  assign in_stall_o = s1_valid_q && !s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      s1_cmd_q <= command_i;
      s1_now_q <= now_us_i;
      s1_pin_q <= pin_level_i;
    end
  end

  // --------------------------------------------------------------------------
  // Gesture state
  // --------------------------------------------------------------------------
  logic [WINDOW_SAMPLES-1:0] win_q, win_d;
  logic [ONES_W-1:0]         ones_q, ones_d;
  logic        deb_q, deb_d;
  logic        stable_q, stable_d;
  logic        pconf_q, pconf_d;
  logic [31:0] last_sample_q, last_sample_d;
  logic [31:0] last_gest_q, last_gest_d;
  logic        gest_valid_q, gest_valid_d;
  logic [31:0] conf_time_q, conf_time_d;
  logic        conf_valid_q, conf_valid_d;
  logic        long_fired_q, long_fired_d;
  logic        dbl_fired_q, dbl_fired_d;
  logic [31:0] short_rel_q, short_rel_d;
  logic        waiting_q, waiting_d;
  logic        pending_q, pending_d;

  // step results
  logic        f_short, f_long, f_double;
  logic [22:0] hold;

  // step datapath
  logic [31:0] since_gest, since_rel, since_sample, since_conf;
  logic        sample_bit;
  logic [WINDOW_SAMPLES-1:0] win_new;
  logic [ONES_W-1:0]         ones_new;
  logic        release_hit;
  logic [60:0] hold_prod;
  logic        ws, ps, lf;

  assign since_gest   = s1_now_q - last_gest_q;
  assign since_rel    = s1_now_q - short_rel_q;
  assign since_sample = s1_now_q - last_sample_q;
  assign since_conf   = s1_now_q - conf_time_q;
  assign sample_bit   = s1_pin_q ^ active_low_q;

  // window is a shift line: the dropped tap is the oldest sample, shifted out
  assign win_new  = {win_q[WINDOW_SAMPLES-2:0], sample_bit};
  assign ones_new = ones_q + ONES_W'(sample_bit) - ONES_W'(win_q[WINDOW_SAMPLES-1]);
  assign release_hit = ({1'b0, ones_new} + {1'b0, thr_q})
                       <= (ONES_W + 1)'(WINDOW_SAMPLES);
  assign hold_prod = 61'(since_conf) * 61'(bgd_pkg::DIV1000_MUL);

  // one item step
  always_comb begin
    win_d         = win_q;
    ones_d        = ones_q;
    deb_d         = deb_q;
    stable_d      = stable_q;
    pconf_d       = pconf_q;
    last_sample_d = last_sample_q;
    last_gest_d   = last_gest_q;
    gest_valid_d  = gest_valid_q;
    conf_time_d   = conf_time_q;
    conf_valid_d  = conf_valid_q;
    dbl_fired_d   = dbl_fired_q;
    short_rel_d   = short_rel_q;
    ws            = waiting_q;
    ps            = pending_q;
    lf            = long_fired_q;
    f_short       = 1'b0;
    f_long        = 1'b0;
    f_double      = 1'b0;
    hold          = 23'd0;

    if (proc) begin
      if (s1_cmd_q) begin
        // arm: only an idle, released button starts a session
        if (!deb_q && !stable_q) begin
          deb_d         = 1'b1;
          pconf_d       = 1'b0;
          win_d         = '0;
          ones_d        = '0;
          last_sample_d = s1_now_q;
        end
      end else begin
        // gesture timeout drops pending gestures
        if (gest_valid_q && (since_gest > timeout_us_q)) begin
          ws = 1'b0;
          ps = 1'b0;
        end
        // late pending short press
        if (!deb_q && dbl_en_q && ws && ps && (since_rel > dbl_win_us_q)) begin
          f_short = 1'b1;
          ps      = 1'b0;
          ws      = 1'b0;
        end
        // take a sample once the interval has run out
        if (deb_q && (since_sample >= sample_us_q)) begin
          last_sample_d = s1_now_q;
          win_d         = win_new;
          ones_d        = ones_new;
          if (!pconf_q) begin
            // press confirm
            if (ones_new >= thr_q) begin
              stable_d     = 1'b1;
              pconf_d      = 1'b1;
              last_gest_d  = s1_now_q;
              gest_valid_d = 1'b1;
              if (long_en_q) begin
                conf_time_d  = s1_now_q;
                conf_valid_d = 1'b1;
                lf           = 1'b0;
              end
              if (dbl_en_q && ws) begin
                if (since_rel > dbl_win_us_q) begin
                  ws          = 1'b0;
                  dbl_fired_d = 1'b0;
                end
              end else begin
                ps = 1'b1;
              end
            end
          end else begin
            // long press while held
            if (long_en_q && !long_fired_q && conf_valid_q
                && (since_conf >= long_us_q)) begin
              f_long = 1'b1;
              hold   = hold_prod[60:bgd_pkg::DIV1000_SHIFT];
              lf     = 1'b1;
              ws     = 1'b0;
            end
            // release confirm
            if (release_hit) begin
              stable_d = 1'b0;
              pconf_d  = 1'b0;
              deb_d    = 1'b0;
              win_d    = '0;
              ones_d   = '0;
              if (dbl_en_q && !lf) begin
                if (ws) begin
                  if (since_rel <= dbl_win_us_q) begin
                    f_double    = 1'b1;
                    dbl_fired_d = 1'b1;
                  end
                  ws = 1'b0;
                end else begin
                  short_rel_d = s1_now_q;
                  ws          = 1'b1;
                end
              end else if (!lf && !dbl_fired_q) begin
                f_short = 1'b1;
                ps      = 1'b0;
              end
            end
          end
        end
      end
    end

    // enable changes from the register port
    long_fired_d = long_en_chg ? 1'b0 : lf;
    waiting_d    = dbl_en_chg ? 1'b0 : ws;
    pending_d    = ps;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q         <= '0;
      ones_q        <= '0;
      deb_q         <= 1'b0;
      stable_q      <= 1'b0;
      pconf_q       <= 1'b0;
      last_sample_q <= 32'd0;
      last_gest_q   <= 32'd0;
      gest_valid_q  <= 1'b0;
      conf_time_q   <= 32'd0;
      conf_valid_q  <= 1'b0;
      long_fired_q  <= 1'b0;
      dbl_fired_q   <= 1'b0;
      short_rel_q   <= 32'd0;
      waiting_q     <= 1'b0;
      pending_q     <= 1'b0;
    end else begin
      win_q         <= win_d;
      ones_q        <= ones_d;
      deb_q         <= deb_d;
      stable_q      <= stable_d;
      pconf_q       <= pconf_d;
      last_sample_q <= last_sample_d;
      last_gest_q   <= last_gest_d;
      gest_valid_q  <= gest_valid_d;
      conf_time_q   <= conf_time_d;
      conf_valid_q  <= conf_valid_d;
      long_fired_q  <= long_fired_d;
      dbl_fired_q   <= dbl_fired_d;
      short_rel_q   <= short_rel_d;
      waiting_q     <= waiting_d;
      pending_q     <= pending_d;
    end
  end

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (proc) begin
      out_valid_o <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc) begin
      stable_pressed_o    <= stable_d;
      short_press_fire_o  <= f_short;
      long_press_fire_o   <= f_long;
      hold_ms_o           <= hold;
      double_press_fire_o <= f_double;
    end
  end

endmodule

// ===== hdl/bgd_checker.sv =====
// ----------------------------------------------------------------------------
// bgd_checker
// Port-level checks of the button gesture debouncer, bound to the top level.
// ----------------------------------------------------------------------------
`include "button_gesture_debouncer_assert.svh"

module bgd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        stable_pressed_o,
  input logic        short_press_fire_o,
  input logic        long_press_fire_o,
  input logic [22:0] hold_ms_o,
  input logic        double_press_fire_o
);

  // at most one gesture flag per result
  `BGD_ASSERT_IMPL(a_one_flag, clk_i, rst_ni, out_valid_o,
    $onehot0({short_press_fire_o, long_press_fire_o, double_press_fire_o}))

  // hold time is only reported with a long press
  `BGD_ASSERT_IMPL(a_hold_zero, clk_i, rst_ni, out_valid_o && !long_press_fire_o,
    hold_ms_o == 23'd0)

  // a double press is reported on the release transaction
  `BGD_ASSERT_IMPL(a_double_released, clk_i, rst_ni,
    out_valid_o && double_press_fire_o, !stable_pressed_o)

  // a stalled result stays valid and keeps its pressed state and hold time
  `BGD_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i,
    out_valid_o && $stable(stable_pressed_o) && $stable(hold_ms_o))

endmodule

bind button_gesture_debouncer bgd_checker u_bgd_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .out_valid_o         (out_valid_o),
  .out_stall_i         (out_stall_i),
  .stable_pressed_o    (stable_pressed_o),
  .short_press_fire_o  (short_press_fire_o),
  .long_press_fire_o   (long_press_fire_o),
  .hold_ms_o           (hold_ms_o),
  .double_press_fire_o (double_press_fire_o)
);
